### design/sik_pkg.sv
// ----------------------------------------------------------------------------
// sik_pkg
// Shared types, constants and the arctangent table for the scara inverse
// kinematics core.
// ----------------------------------------------------------------------------
package sik_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int CW            = 50;   // cordic x/y width
  localparam int ZW            = 32;   // cordic angle width, q16.16 degrees
  localparam int DIV_BITS      = 30;
  localparam int SQRT_STEPS    = 31;
  localparam int LAT           = 74 + CORDIC_STAGES;

  localparam logic signed [ZW-1:0] DEG90     = 32'sd5898240;
  localparam logic signed [ZW-1:0] ANG_LIMIT = 32'sd47185920;

  typedef enum logic [1:0] {
    CFG_ARM_LENGTH_1 = 2'd0,
    CFG_ARM_LENGTH_2 = 2'd1,
    CFG_ORIGIN_X     = 2'd2,
    CFG_ORIGIN_Y     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
  } req_t;

  typedef struct packed {
    logic signed [26:0] base_angle;
    logic signed [26:0] sub_arm_angle;
    logic signed [31:0] z_out;
    logic               unreachable;
  } rsp_t;

  // fields that ride along the pipeline beside the main datapath
  typedef struct packed {
    logic signed [32:0] sx;
    logic signed [32:0] sy;
    logic signed [31:0] z;
    logic               neg;
    logic               clamp;
    logic               unreach;
    logic signed [31:0] c2;
    logic [30:0]        s2;
  } side_t;

  // atan(2^-i) in q16.16 degrees, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = 32'sd2949120;
      1:  r = 32'sd1740967;
      2:  r = 32'sd919879;
      3:  r = 32'sd466945;
      4:  r = 32'sd234379;
      5:  r = 32'sd117304;
      6:  r = 32'sd58666;
      7:  r = 32'sd29335;
      8:  r = 32'sd14668;
      9:  r = 32'sd7334;
      10: r = 32'sd3667;
      11: r = 32'sd1833;
      12: r = 32'sd917;
      13: r = 32'sd458;
      14: r = 32'sd229;
      15: r = 32'sd115;
      16: r = 32'sd57;
      17: r = 32'sd29;
      18: r = 32'sd14;
      19: r = 32'sd7;
      20: r = 32'sd4;
      21: r = 32'sd2;
      22: r = 32'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### design/sik_cordic.sv
// ----------------------------------------------------------------------------
// sik_cordic
// Pipelined vectoring cordic: atan2(y, x) in q16.16 degrees, one registered stage per iteration.
// ----------------------------------------------------------------------------
module sik_cordic (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [sik_pkg::CW-1:0]     y_in,
  input  logic signed [sik_pkg::CW-1:0]     x_in,
  output logic signed [sik_pkg::ZW-1:0]     z_out
);

  localparam int CS = sik_pkg::CORDIC_STAGES;

  logic signed [sik_pkg::CW-1:0] xs [0:CS];
  logic signed [sik_pkg::CW-1:0] ys [0:CS];
  logic signed [sik_pkg::ZW-1:0] zs [0:CS];
  logic                          zero [0:CS];

  logic signed [sik_pkg::CW-1:0] x0, y0;
  logic signed [sik_pkg::ZW-1:0] z0;

  // left half plane is turned by a quarter first
  always_comb begin
    x0 = x_in;
    y0 = y_in;
    z0 = '0;
    if (x_in < 0) begin
      if (y_in >= 0) begin
        x0 = y_in;
        y0 = -x_in;
        z0 = sik_pkg::DEG90;
      end else begin
        x0 = -y_in;
        y0 = x_in;
        z0 = -sik_pkg::DEG90;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]   <= x0;
      ys[0]   <= y0;
      zs[0]   <= z0;
      zero[0] <= (x_in == '0) && (y_in == '0);
    end
  end

  for (genvar i = 0; i < CS; i++) begin : g_stage
    logic signed [sik_pkg::CW-1:0] dx, dy;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!ys[i][sik_pkg::CW-1]) begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + sik_pkg::atan_entry(i);
        end else begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - sik_pkg::atan_entry(i);
        end
        zero[i+1] <= zero[i];
      end
    end
  end

  assign z_out = zero[CS] ? '0 : zs[CS];

endmodule

### design/scara_inverse_kinematics_core.sv
// ----------------------------------------------------------------------------
// scara_inverse_kinematics_core
// Two-link arm inverse kinematics: target position in, joint angles out.
// ----------------------------------------------------------------------------
// One item is taken every cycle unless req_stall is high. The pipeline depth
// is set by the chain of one-bit-a-stage units: a 30-stage restoring divider
// for the elbow cosine, a 31-stage integer square root for the elbow sine,
// and three parallel cordic pipelines for the arctangents. The whole pipeline
// holds while a finished result is stalled at the output register. The user
// must write the configuration registers only while no item is in flight;
// the block itself does not enforce this.
module scara_inverse_kinematics_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sik_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sik_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  localparam int CS       = sik_pkg::CORDIC_STAGES;
  localparam int LAT      = sik_pkg::LAT;
  localparam int SIDE_N   = LAT - 1;
  localparam int ST_MAG   = 3;
  localparam int ST_CMP   = 4;
  localparam int ST_C2    = ST_CMP + sik_pkg::DIV_BITS + 1;
  localparam int ST_T     = ST_C2 + 2;
  localparam int ST_PROD  = ST_T + sik_pkg::SQRT_STEPS + 1;
  localparam int ST_SK    = ST_PROD + 1;
  localparam int ST_ANG   = ST_SK + CS + 2;

  // configuration
  logic [30:0]        arm_length_1, arm_length_2;
  logic signed [31:0] origin_x, origin_y;
  logic [45:0]        a1_sq, a2_sq, a1a2;
  logic [46:0]        den;

  always_ff @(posedge clk) begin
    if (rst) begin
      arm_length_1 <= 31'd9830400;
      arm_length_2 <= 31'd9830400;
      origin_x     <= '0;
      origin_y     <= '0;
    end else if (cfg_we) begin
      unique case (sik_pkg::cfg_reg_e'(cfg_index))
        sik_pkg::CFG_ARM_LENGTH_1: arm_length_1 <= cfg_data[30:0];
        sik_pkg::CFG_ARM_LENGTH_2: arm_length_2 <= cfg_data[30:0];
        sik_pkg::CFG_ORIGIN_X:     origin_x     <= cfg_data;
        sik_pkg::CFG_ORIGIN_Y:     origin_y     <= cfg_data;
      endcase
    end
  end

  // terms that depend on the arm lengths only
  always_ff @(posedge clk) begin
    a1_sq <= 46'(arm_length_1[30:8]) * 46'(arm_length_1[30:8]);
    a2_sq <= 46'(arm_length_2[30:8]) * 46'(arm_length_2[30:8]);
    a1a2  <= 46'(arm_length_1[30:8]) * 46'(arm_length_2[30:8]);
  end
  assign den = {a1a2, 1'b0};

  // pipeline control
  logic advance;
  logic vld [0:LAT-1];

  assign advance   = !(vld[LAT-1] && rsp_stall);
  assign req_stall = !advance;
  assign rsp_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (advance) begin
      vld[0] <= req_valid;
      for (int k = 1; k < LAT; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  // side fields
  sik_pkg::side_t side      [0:SIDE_N-1];
  sik_pkg::side_t side_next [0:SIDE_N-1];

  logic [48:0]        ax2, ay2;
  logic signed [50:0] num_r;
  logic [49:0]        mag_r;
  logic [46:0]        div_rem [0:sik_pkg::DIV_BITS-1];
  logic [29:0]        div_q   [1:sik_pkg::DIV_BITS];
  logic signed [31:0] c2_val;
  logic [30:0]        c2m_r;
  logic [60:0]        csq_r;
  logic [60:0]        sq_t [0:sik_pkg::SQRT_STEPS-1];
  logic [61:0]        sq_r [1:sik_pkg::SQRT_STEPS];
  logic signed [63:0] p1_r;
  logic [61:0]        p2_r;
  logic signed [63:0] sk_sum;
  logic signed [47:0] sk1_r;
  logic [45:0]        sk2_r;
  logic signed [sik_pkg::ZW-1:0] za, zb, zc, theta_r, psi_r;

  always_comb begin
    side_next[0]         = '0;
    side_next[0].sx      = $signed({req.target_x[31], req.target_x})
                           - $signed({origin_x[31], origin_x});
    side_next[0].sy      = $signed({req.target_y[31], req.target_y})
                           - $signed({origin_y[31], origin_y});
    side_next[0].z       = req.target_z;
    for (int k = 1; k < SIDE_N; k++) begin
      side_next[k] = side[k-1];
    end
    side_next[ST_MAG].neg     = num_r[50];
    side_next[ST_CMP].clamp   = mag_r >= {3'b0, den};
    side_next[ST_CMP].unreach = mag_r > {3'b0, den};
    side_next[ST_C2].c2       = c2_val;
    side_next[ST_PROD].s2     = sq_r[sik_pkg::SQRT_STEPS][30:0];
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < SIDE_N; k++) begin
        side[k] <= side_next[k];
      end
    end
  end

  // squares and elbow cosine numerator
  logic signed [49:0] ax_full, ay_full;
  assign ax_full = 50'($signed(side[0].sx[32:8])) * 50'($signed(side[0].sx[32:8]));
  assign ay_full = 50'($signed(side[0].sy[32:8])) * 50'($signed(side[0].sy[32:8]));

  always_ff @(posedge clk) begin
    if (advance) begin
      ax2   <= ax_full[48:0];
      ay2   <= ay_full[48:0];
      num_r <= $signed({2'b0, ax2}) + $signed({2'b0, ay2})
               - $signed({5'b0, a1_sq}) - $signed({5'b0, a2_sq});
      mag_r <= num_r[50] ? 50'(-num_r) : num_r[49:0];
      div_rem[0] <= mag_r[46:0];
    end
  end

  // restoring divider, one quotient bit a stage
  for (genvar j = 0; j < sik_pkg::DIV_BITS; j++) begin : g_div
    logic [47:0] sh;
    logic [29:0] qi;
    logic        take;
    assign sh   = {div_rem[j], 1'b0};
    assign take = sh >= {1'b0, den};
    if (j == 0) begin : g_first
      assign qi = '0;
    end else begin : g_rest
      assign qi = div_q[j];
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        div_q[j+1] <= {qi[28:0], take};
      end
    end
    if (j < sik_pkg::DIV_BITS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (advance) begin
          if (take) begin
            div_rem[j+1] <= 47'(sh - {1'b0, den});
          end else begin
            div_rem[j+1] <= sh[46:0];
          end
        end
      end
    end
  end

  // clamped cosine in q30
  always_comb begin
    if (side[ST_C2-1].clamp) begin
      c2_val = side[ST_C2-1].neg ? -32'sd1073741824 : 32'sd1073741824;
    end else begin
      c2_val = side[ST_C2-1].neg ? -$signed({2'b0, div_q[sik_pkg::DIV_BITS]})
                                 : $signed({2'b0, div_q[sik_pkg::DIV_BITS]});
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c2m_r   <= side[ST_C2-1].clamp ? 31'h4000_0000
                                     : {1'b0, div_q[sik_pkg::DIV_BITS]};
      csq_r   <= 61'(c2m_r) * 61'(c2m_r);
      sq_t[0] <= 61'h1000_0000_0000_0000 - csq_r;
    end
  end

  // integer square root, two radicand bits a stage
  for (genvar k = 0; k < sik_pkg::SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
    logic [61:0] ri, sum;
    if (k == 0) begin : g_first
      assign ri = '0;
    end else begin : g_rest
      assign ri = sq_r[k];
    end
    assign sum = ri + BIT;
    always_ff @(posedge clk) begin
      if (advance) begin
        if ({1'b0, sq_t[k]} >= sum) begin
          sq_r[k+1] <= (ri >> 1) + BIT;
        end else begin
          sq_r[k+1] <= ri >> 1;
        end
      end
    end
    if (k < sik_pkg::SQRT_STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (advance) begin
          if ({1'b0, sq_t[k]} >= sum) begin
            sq_t[k+1] <= 61'({1'b0, sq_t[k]} - sum);
          end else begin
            sq_t[k+1] <= sq_t[k];
          end
        end
      end
    end
  end

  // wrist vector sk1, sk2
  assign sk_sum = $signed({3'b0, arm_length_1, 30'b0}) + p1_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      p1_r  <= 64'($signed({1'b0, arm_length_2})) * 64'(side[ST_PROD-1].c2);
      p2_r  <= {31'b0, arm_length_2} * {31'b0, sq_r[sik_pkg::SQRT_STEPS][30:0]};
      sk1_r <= sk_sum[63:16];
      sk2_r <= p2_r[61:16];
    end
  end

  sik_cordic u_cordic_wrist (
    .clk   (clk),
    .en    (advance),
    .y_in  ({{(sik_pkg::CW-48){sk1_r[47]}}, sk1_r}),
    .x_in  ({{(sik_pkg::CW-46){1'b0}}, sk2_r}),
    .z_out (za)
  );

  sik_cordic u_cordic_target (
    .clk   (clk),
    .en    (advance),
    .y_in  ({{(sik_pkg::CW-33){side[ST_SK].sx[32]}}, side[ST_SK].sx}),
    .x_in  ({{(sik_pkg::CW-33){side[ST_SK].sy[32]}}, side[ST_SK].sy}),
    .z_out (zb)
  );

  sik_cordic u_cordic_elbow (
    .clk   (clk),
    .en    (advance),
    .y_in  ({{(sik_pkg::CW-31){1'b0}}, side[ST_SK].s2}),
    .x_in  ({{(sik_pkg::CW-32){side[ST_SK].c2[31]}}, side[ST_SK].c2}),
    .z_out (zc)
  );

  function automatic logic signed [26:0] clamp_angle(input logic signed [31:0] a);
    logic signed [31:0] r;
    r = a;
    if (a > sik_pkg::ANG_LIMIT) begin
      r = sik_pkg::ANG_LIMIT;
    end else if (a < -sik_pkg::ANG_LIMIT) begin
      r = -sik_pkg::ANG_LIMIT;
    end
    return r[26:0];
  endfunction

  always_ff @(posedge clk) begin
    if (advance) begin
      theta_r           <= za - zb;
      psi_r             <= zc;
      rsp.base_angle    <= clamp_angle(theta_r);
      rsp.sub_arm_angle <= clamp_angle(theta_r + psi_r);
      rsp.z_out         <= side[ST_ANG].z;
      rsp.unreachable   <= side[ST_ANG].unreach;
    end
  end

endmodule
